// ----- src/tcons_pkg.sv -----
// Shared types, constants and command codes for the text console.
package tcons_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W      = 3;

    localparam logic [7:0]  ATTR_RESET  = 8'h0F;
    localparam logic [15:0] BLANK_RESET = 16'h0F20;
    localparam logic [7:0]  CH_LF       = 8'h0A;
    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_SPACE    = 8'h20;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic REG_IDX_ATTR = 1'b0;

    typedef enum logic [1:0] {
        OP_GLYPH = 2'd0,
        OP_LF    = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } req_beat_t;

    typedef struct packed {
        logic [7:0]  serial_byte;
        logic [15:0] cell_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
        logic        last;
    } rsp_beat_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } cmd_t;

endpackage

// ----- src/tcons_front.sv -----
// Request front end: accepts beats and classifies them into commands.
module tcons_front
    import tcons_pkg::*;
(
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    input  logic      queue_full,
    input  logic      back_busy,
    output logic      push,
    output cmd_t      cmd
);

    assign req_stall = queue_full || back_busy;
    assign push      = req_valid && !req_stall;

    always_comb
    begin
        cmd.char_code  = req.char_code;
        cmd.cell_index = req.cell_index;
        if (req.kind == KIND_READ)
        begin
            cmd.op = OP_READ;
        end
        else if (req.char_code == CH_LF)
        begin
            cmd.op = OP_LF;
        end
        else
        begin
            cmd.op = OP_GLYPH;
        end
    end

endmodule

// ----- src/tcons_queue.sv -----
// Short command queue between the front end and the screen engine.
module tcons_queue
    import tcons_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t rd_data
);

    cmd_t             store [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QPW:0]     count_reg;

    localparam logic [QPW:0]   DEPTH_C = (QPW + 1)'(QUEUE_DEPTH);
    localparam logic [QPW-1:0] PTR_LAST = QPW'(QUEUE_DEPTH - 1);

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign rd_data   = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/tcons_back.sv -----
// Screen engine: cursor, circular screen memory, scroll clearing and result register.
module tcons_back
    import tcons_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    input  logic [7:0] attr,
    output logic      busy,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    localparam int CC  = ROWS * COLUMNS;
    localparam int AW  = $clog2(CC);
    localparam int RW  = $clog2(ROWS);
    localparam int CLW = $clog2(COLUMNS);
    localparam int CW  = ((AW > 11) ? AW : 11) + 1;

    localparam logic [AW:0]    CC_W     = (AW + 1)'(CC);
    localparam logic [CW-1:0]  CC_CW    = CW'(CC);
    localparam logic [AW-1:0]  COLS_A   = AW'(COLUMNS);
    localparam logic [AW-1:0]  LAST_A   = AW'(CC - 1);
    localparam logic [CLW-1:0] COL_LAST = CLW'(COLUMNS - 1);
    localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_LF     = 5'b01000,
        S_SCROLL = 5'b10000
    } state_t;

    logic [15:0] mem [CC];
    logic [15:0] rd_data_reg;

    state_t          state_reg, state_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CLW-1:0]  col_reg, col_next;
    logic [AW-1:0]   rowbase_reg, rowbase_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [CLW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic            scr_reg, scr_next;
    logic            oor_reg, oor_next;
    logic            out_valid_reg, out_valid_next;
    rsp_beat_t       out_reg, out_next;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [15:0]     mem_wdata;

    logic            out_free;
    logic            adv, at_last, scroll;
    logic [AW:0]     wr_sum, rd_sum, base_sum;
    logic [AW-1:0]   wr_phys, rd_phys;
    logic [CW-1:0]   idx_w;
    logic            idx_ok;
    logic [31:0]     row_w, col_w;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign busy      = (state_reg == S_INIT);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign adv     = (cmd.op == OP_LF) || (col_reg == COL_LAST);
    assign at_last = (row_reg == ROW_LAST);
    assign scroll  = adv && at_last;

    // logical address plus top-of-screen offset, wrapped once
    assign wr_sum  = (AW + 1)'(rowbase_reg) + (AW + 1)'(col_reg) + (AW + 1)'(base_reg);
    assign wr_phys = (wr_sum >= CC_W) ? AW'(wr_sum - CC_W) : wr_sum[AW-1:0];

    assign idx_w   = CW'(cmd.cell_index);
    assign idx_ok  = (idx_w < CC_CW);
    assign rd_sum  = (AW + 1)'(idx_w[AW-1:0]) + (AW + 1)'(base_reg);
    assign rd_phys = (rd_sum >= CC_W) ? AW'(rd_sum - CC_W) : rd_sum[AW-1:0];

    assign base_sum = (AW + 1)'(base_reg) + (AW + 1)'(COLS_A);

    assign row_w = 32'(row_next);
    assign col_w = 32'(col_next);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rowbase_next   = rowbase_reg;
        base_next      = base_reg;
        clr_addr_next  = clr_addr_reg;
        clr_cnt_next   = clr_cnt_reg;
        scr_next       = scr_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = clr_addr_reg;
        mem_raddr      = rd_phys;
        mem_wdata      = {attr, CH_SPACE};

        case (state_reg)
            S_INIT:
            begin
                mem_we        = 1'b1;
                mem_wdata     = BLANK_RESET;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_A)
                begin
                    clr_addr_next = '0;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.op == OP_READ)
                    begin
                        mem_re     = idx_ok;
                        oor_next   = !idx_ok;
                        state_next = S_READ;
                    end
                    else
                    begin
                        if (cmd.op == OP_GLYPH)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = wr_phys;
                            mem_wdata = {attr, cmd.char_code};
                        end
                        if (adv)
                        begin
                            col_next = '0;
                            if (at_last)
                            begin
                                clr_addr_next = base_reg;
                                clr_cnt_next  = '0;
                                base_next     = (base_sum == CC_W) ? '0 : base_sum[AW-1:0];
                            end
                            else
                            begin
                                row_next     = row_reg + 1'b1;
                                rowbase_next = rowbase_reg + COLS_A;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        scr_next       = scroll;
                        out_valid_next = 1'b1;
                        out_next.cell_data = '0;
                        out_next.scrolled  = scroll;
                        if (cmd.op == OP_LF)
                        begin
                            out_next.serial_byte = CH_CR;
                            out_next.last        = 1'b0;
                            state_next           = S_LF;
                        end
                        else
                        begin
                            out_next.serial_byte = cmd.char_code;
                            out_next.last        = 1'b1;
                            state_next           = scroll ? S_SCROLL : S_IDLE;
                        end
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.serial_byte = '0;
                    out_next.cell_data   = oor_reg ? 16'h0000 : rd_data_reg;
                    out_next.scrolled    = 1'b0;
                    out_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            S_LF:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.serial_byte = CH_LF;
                    out_next.cell_data   = '0;
                    out_next.scrolled    = scr_reg;
                    out_next.last        = 1'b1;
                    state_next           = scr_reg ? S_SCROLL : S_IDLE;
                end
            end
            S_SCROLL:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == COL_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_valid_next && !(out_valid_reg && rsp_stall))
        begin
            out_next.cursor_row = row_w[4:0];
            out_next.cursor_col = col_w[6:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            rowbase_reg   <= '0;
            base_reg      <= '0;
            clr_addr_reg  <= '0;
            clr_cnt_reg   <= '0;
            scr_reg       <= 1'b0;
            oor_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            rowbase_reg   <= rowbase_next;
            base_reg      <= base_next;
            clr_addr_reg  <= clr_addr_next;
            clr_cnt_reg   <= clr_cnt_next;
            scr_reg       <= scr_next;
            oor_reg       <= oor_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/text_console_with_scroll_unit.sv -----
// Text console top level: APB attribute register, front end, queue and screen engine.
// Throughput: one glyph per cycle while rsp_stall is low; a line feed sends CR then
// LF, a read waits on the memory read, and a scroll adds bottom-row clearing.
// Reset: asynchronous; afterwards a clearing pass over all ROWS*COLUMNS cells
// fills the screen memory with blanks, and no request beat is taken until it ends.
module text_console_with_scroll_unit
    import tcons_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_beat_t         req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_beat_t         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] attr_reg;
    logic       queue_full, back_busy, push, pop, not_empty;
    cmd_t       push_cmd, head_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_ATTR) ? {24'h000000, attr_reg} : 32'h00000000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_ATTR))
        begin
            attr_reg <= pwdata[7:0];
        end
    end

    tcons_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (queue_full),
        .back_busy  (back_busy),
        .push       (push),
        .cmd        (push_cmd)
    );

    tcons_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_data   (head_cmd)
    );

    tcons_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .attr      (attr_reg),
        .busy      (back_busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
